FILE: sv/owc_pkg.sv
// shared types and constants of the overlapping window chunker
`default_nettype none
package owc_pkg;

  localparam int unsigned PosBits           = 40;
  localparam int unsigned OutBits           = PosBits + 1;
  localparam int unsigned LenBits           = 16;
  localparam int unsigned RegBits           = 12;
  localparam int unsigned WinBits           = RegBits + 2;
  localparam int unsigned OvlBits           = RegBits + 1;
  localparam int unsigned MaxWindowsDefault = 31;
  localparam int unsigned PatternLenReset   = 100;
  localparam int unsigned MaxErrorReset     = 0;

  typedef enum logic [1:0] {
    CFG_KEY_LEN   = 2'd0,
    CFG_ERR_LIMIT = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_WIN,
    ST_OVL,
    ST_TAIL,
    ST_TOO_LONG
  } chunk_state_e;

  typedef struct packed {
    logic [PosBits-1:0] region_begin;
    logic [LenBits-1:0] region_length;
  } region_t;

  typedef struct packed {
    logic [OutBits-1:0] chunk_begin;
    logic [OutBits-1:0] chunk_end;
    logic               chunk_last;
    logic               too_long;
  } chunk_t;

  typedef struct packed {
    logic done;
    logic too_long;
  } div_flags_t;

endpackage
`default_nettype wire

FILE: sv/owc_div.sv
// iterative subtract-and-count unit: number of full windows and remainder
`default_nettype none
module owc_div
  import owc_pkg::*;
#(
  parameter int unsigned MAX_WINDOWS = MaxWindowsDefault,
  parameter int unsigned CW          = $clog2(MAX_WINDOWS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [LenBits-1:0] len_i,
  input  logic [WinBits-1:0] win_i,
  output div_flags_t         flags_o,
  output logic [CW-1:0]      nwin_o,
  output logic [LenBits-1:0] rem_o
);

  localparam logic [CW-1:0] CntMax = CW'(MAX_WINDOWS);

  logic               busy_q, busy_d;
  logic [LenBits-1:0] rem_q, rem_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               fits;
  logic               at_max;

  assign fits   = rem_q >= LenBits'(win_i);
  assign at_max = cnt_q == CntMax;

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = len_i;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (fits && !at_max) begin
        rem_d = rem_q - LenBits'(win_i);
        cnt_d = cnt_q + CW'(1);
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign flags_o.done     = busy_q && !(fits && !at_max);
  assign flags_o.too_long = busy_q && fits && at_max;
  assign nwin_o           = cnt_q;
  assign rem_o            = rem_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("window count beyond limit");

  a_too_long_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_o.too_long |-> flags_o.done)
    else $error("too_long without done");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_o.done && !start_i |=> !busy_q)
    else $error("unit still busy after done");

endmodule
`default_nettype wire

FILE: sv/overlapping_window_chunker.sv
// top level: cuts a text region into overlapping candidate windows
// Usage: a region item (begin, length) enters on the in channel when in_valid_i
// is high and in_stall_o is low; only one region is worked on at a time.
// Config (key length, error limit) is written through cfg_we_i/cfg_idx_i/
// cfg_data_i while idle; window length is key length + 2*error limit.
// Per region the subtract unit first counts full windows, one
// compare/subtract per cycle. Then chunks leave one per cycle from the
// output register while the receiver does not stall: each window, an
// overlap chunk before every window but the first, and an optional tail,
// so 2*nwin - 1 or 2*nwin chunks (one with no window). A region
// that holds more than MAX_WINDOWS windows (or a zero window) gives one
// too_long item.
// The next region is taken as soon as the last chunk sits in the output
// register.
// When the receiver stalls, the output register holds its item and the
// chunk sequence pauses. Reset clears the sequencer and the output valid
// and loads key length 100, error limit 0.
`default_nettype none
module overlapping_window_chunker
  import owc_pkg::*;
#(
  parameter int unsigned MAX_WINDOWS = MaxWindowsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [RegBits-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  region_t            in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output chunk_t             out_item_o
);

  localparam int unsigned CW = $clog2(MAX_WINDOWS + 1);

  logic [RegBits-1:0] pat_len_q, max_err_q;
  logic [WinBits-1:0] win;
  logic [OvlBits-1:0] ovl;

  chunk_state_e       state_q, state_d;
  logic [PosBits-1:0] base_q, base_d;
  logic [OutBits-1:0] end_q, end_d;
  logic [OutBits-1:0] cur_q, cur_d;
  logic [LenBits-1:0] off_q, off_d;
  logic [LenBits-1:0] span_q, span_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  chunk_t             out_q, out_d;

  logic               in_accept;
  logic               out_free;
  logic               load;
  logic               last_win;
  logic               tail_needed;
  div_flags_t         div_flags;
  logic [CW-1:0]      nwin;
  logic [LenBits-1:0] div_rem;

  assign win = WinBits'(pat_len_q) + {1'b0, max_err_q, 1'b0};
  assign ovl = OvlBits'(pat_len_q) + OvlBits'(max_err_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= RegBits'(PatternLenReset);
      max_err_q <= RegBits'(MaxErrorReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_LEN:   pat_len_q <= cfg_data_i;
        CFG_ERR_LIMIT: max_err_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  assign in_stall_o = state_q != ST_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  owc_div #(
    .MAX_WINDOWS(MAX_WINDOWS),
    .CW         (CW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_accept),
    .len_i  (in_item_i.region_length),
    .win_i  (win),
    .flags_o(div_flags),
    .nwin_o (nwin),
    .rem_o  (div_rem)
  );

  assign last_win    = ({1'b0, idx_q} + (CW + 1)'(1)) == {1'b0, nwin};
  assign tail_needed = (nwin == '0) || (div_rem > LenBits'(ovl));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_COUNT;
      end
      ST_COUNT: begin
        if (div_flags.done) begin
          if (div_flags.too_long) state_d = ST_TOO_LONG;
          else if (nwin == '0)    state_d = ST_TAIL;
          else                    state_d = ST_WIN;
        end
      end
      ST_WIN: begin
        if (out_free) begin
          if (!last_win)        state_d = ST_OVL;
          else if (tail_needed) state_d = ST_TAIL;
          else                  state_d = ST_IDLE;
        end
      end
      ST_OVL: begin
        if (out_free) state_d = ST_WIN;
      end
      ST_TAIL, ST_TOO_LONG: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and output register loading
  always_comb begin
    base_d = base_q;
    end_d  = end_q;
    cur_d  = cur_q;
    off_d  = off_q;
    span_d = span_q;
    idx_d  = idx_q;
    load   = 1'b0;
    out_d  = out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          base_d = in_item_i.region_begin;
          cur_d  = OutBits'(in_item_i.region_begin);
          end_d  = OutBits'(in_item_i.region_begin) + OutBits'(in_item_i.region_length);
          off_d  = '0;
          span_d = in_item_i.region_length;
          idx_d  = '0;
        end
      end
      ST_WIN: begin
        load              = out_free;
        out_d.chunk_begin = cur_q;
        out_d.chunk_end   = cur_q + OutBits'(win);
        out_d.chunk_last  = last_win && !tail_needed;
        out_d.too_long    = 1'b0;
        if (out_free) begin
          cur_d  = cur_q + OutBits'(win);
          off_d  = off_q + LenBits'(win);
          span_d = span_q - LenBits'(win);
          idx_d  = idx_q + CW'(1);
        end
      end
      ST_OVL: begin
        load              = out_free;
        // overlap chunk around the next window start, clamped to the region
        out_d.chunk_begin = (off_q >= LenBits'(ovl)) ? cur_q - OutBits'(ovl)
                                                     : OutBits'(base_q);
        out_d.chunk_end   = (span_q >= LenBits'(ovl)) ? cur_q + OutBits'(ovl) : end_q;
        out_d.chunk_last  = 1'b0;
        out_d.too_long    = 1'b0;
      end
      ST_TAIL: begin
        load              = out_free;
        out_d.chunk_begin = cur_q;
        out_d.chunk_end   = end_q;
        out_d.chunk_last  = 1'b1;
        out_d.too_long    = 1'b0;
      end
      ST_TOO_LONG: begin
        load              = out_free;
        out_d.chunk_begin = '0;
        out_d.chunk_end   = '0;
        out_d.chunk_last  = 1'b1;
        out_d.too_long    = 1'b1;
      end
      default: ;
    endcase
    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    end_q  <= end_d;
    cur_q  <= cur_d;
    off_q  <= off_d;
    span_q <= span_d;
    if (load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_chunk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.too_long |-> out_item_o.chunk_begin <= out_item_o.chunk_end)
    else $error("chunk begin after chunk end");

  a_too_long_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.too_long |->
      out_item_o.chunk_last && out_item_o.chunk_begin == '0 && out_item_o.chunk_end == '0)
    else $error("malformed too_long item");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free)
    else $error("output register overwritten while stalled");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && out_d.chunk_last |=> state_q == ST_IDLE)
    else $error("sequencer busy after last chunk");

endmodule
`default_nettype wire

FILE: verif/overlapping_window_chunker_tb.sv
// self-checking testbench of the overlapping window chunker: random regions, stalls, settings
module overlapping_window_chunker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import owc_pkg::*;

  localparam int unsigned DrainCycles = 100;
  localparam int unsigned HoldCycles  = 400;
  localparam logic [PosBits-1:0] TopBegin = '1;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               cfg_we_i   = 1'b0;
  logic [1:0]         cfg_idx_i  = '0;
  logic [RegBits-1:0] cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  region_t            in_item_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  chunk_t             out_item_o;

  overlapping_window_chunker i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .in_item_i,
    .out_valid_o,
    .out_stall_i,
    .out_item_o
  );

  // local copy of the registers, changed only while the block is idle
  logic [RegBits-1:0] pattern_len = RegBits'(PatternLenReset);
  logic [RegBits-1:0] max_err     = RegBits'(MaxErrorReset);

  region_t region_pending[$];
  chunk_t  expected_chunks[$];

  int unsigned mismatches     = 0;
  int unsigned regions_taken  = 0;
  int unsigned chunks_checked = 0;
  int unsigned too_long_cnt   = 0;
  int unsigned settings_run   = 1;
  int unsigned burst_left     = 0;
  int unsigned gap_left       = 0;
  int unsigned hold_left      = 0;
  int unsigned stall_mode     = 0;
  int unsigned mode_left      = 0;
  bit          held_off       = 1'b0;

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void push_chunk(input longint unsigned b, input longint unsigned e,
                                     input bit last, input bit tl);
    chunk_t c;
    c.chunk_begin = b[OutBits-1:0];
    c.chunk_end   = e[OutBits-1:0];
    c.chunk_last  = last;
    c.too_long    = tl;
    expected_chunks.push_back(c);
  endfunction

  // windows, the overlap chunks between them and an optional tail
  function automatic void cut_region(input region_t r);
    longint unsigned b, len, e, win, ovl, nwin, cur, ob, oe;
    bit tail;
    b   = r.region_begin;
    len = r.region_length;
    e   = b + len;
    win = longint'(pattern_len) + 2 * longint'(max_err);
    ovl = longint'(pattern_len) + longint'(max_err);
    if (win == 0 || len / win > MaxWindowsDefault) begin
      push_chunk(0, 0, 1'b1, 1'b1);
      too_long_cnt++;
      return;
    end
    nwin = len / win;
    cur  = b + nwin * win;
    tail = (nwin == 0) || (cur < e && e - cur > ovl);
    cur  = b;
    for (longint unsigned i = 0; i < nwin; i++) begin
      if (i != 0) begin
        ob = (cur - b >= ovl) ? cur - ovl : b;
        oe = (e - cur >= ovl) ? cur + ovl : e;
        push_chunk(ob, oe, 1'b0, 1'b0);
      end
      push_chunk(cur, cur + win, (i == nwin - 1) && !tail, 1'b0);
      cur += win;
    end
    if (tail) push_chunk(cur, e, 1'b1, 1'b0);
  endfunction

  // mostly region lengths of a few windows, some near the window limit, some anything
  function automatic region_t make_region(input int unsigned win);
    region_t     r;
    int unsigned len;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (win == 0 || pick == 0) len = $urandom_range(0, 65535);
    else if (pick == 1) len = $urandom_range(30, 32) * win + $urandom_range(0, win - 1);
    else len = $urandom_range(0, 8) * win + $urandom_range(0, win);
    if (len > 65535) len = 65535;
    pick = $urandom_range(0, 7);
    if (pick == 0) r.region_begin = '0;
    else if (pick == 1) r.region_begin = TopBegin - PosBits'($urandom_range(0, 4000));
    else r.region_begin = PosBits'({$urandom(), $urandom()});
    r.region_length = len[LenBits-1:0];
    return r;
  endfunction

  task automatic check_chunk(input chunk_t got);
    chunk_t want;
    if (expected_chunks.size() == 0) begin
      report_mismatch($sformatf("chunk %h with nothing expected", got));
      return;
    end
    want = expected_chunks.pop_front();
    if (got.chunk_begin !== want.chunk_begin)
      report_mismatch($sformatf("chunk_begin %0d, want %0d", got.chunk_begin, want.chunk_begin));
    if (got.chunk_end !== want.chunk_end)
      report_mismatch($sformatf("chunk_end %0d, want %0d", got.chunk_end, want.chunk_end));
    if (got.chunk_last !== want.chunk_last)
      report_mismatch($sformatf("chunk_last %b, want %b", got.chunk_last, want.chunk_last));
    if (got.too_long !== want.too_long)
      report_mismatch($sformatf("too_long %b, want %b", got.too_long, want.too_long));
    chunks_checked++;
  endtask

  // sender: bursts of items with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        cut_region(in_item_i);
        regions_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (region_pending.size() > 0) begin
          in_item_i  <= region_pending.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each item, stalls in changing modes, holds off once for a long stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_chunk(out_item_o);
      if (!held_off && regions_taken >= 30) begin
        held_off  = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 120);
        end
        mode_left--;
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [RegBits-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_KEY_LEN:   pattern_len = val;
      CFG_ERR_LIMIT: max_err = val;
      default: ;
    endcase
  endtask

  task automatic add_region(input logic [PosBits-1:0] b, input logic [LenBits-1:0] l);
    region_t r;
    r.region_begin  = b;
    r.region_length = l;
    region_pending.push_back(r);
  endtask

  task automatic wait_drained();
    while (region_pending.size() != 0 || in_valid_i || expected_chunks.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic add_random(input int unsigned n);
    for (int unsigned k = 0; k < n; k++)
      region_pending.push_back(make_region(int'(pattern_len) + 2 * int'(max_err)));
  endtask

  task automatic run_setting(input logic [RegBits-1:0] pl, input logic [RegBits-1:0] me,
                             input int unsigned n);
    write_reg(CFG_KEY_LEN, pl);
    write_reg(CFG_ERR_LIMIT, me);
    settings_run++;
    add_random(n);
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: window 100, overlap 100
    add_region('0, 16'd0);             // empty region, tail only
    add_region(TopBegin, 16'd0);
    add_region(40'd5, 16'd99);         // no window fits
    add_region(40'd7, 16'd100);        // exactly one window
    add_region(40'd1000, 16'd200);
    add_region(40'd1000, 16'd250);
    add_region(40'd42, 16'd305);
    add_region('0, 16'd3100);          // window limit reached exactly
    add_region(40'd123, 16'd3199);
    add_region('0, 16'd3200);          // one window over the limit
    add_region('0, 16'hffff);
    add_region(TopBegin, 16'hffff);
    add_region(TopBegin, 16'd3150);    // chunk positions cross the input width
    add_region(TopBegin - 40'd5, 16'd1);
    add_random(18);
    wait_drained();

    run_setting(12'd1, 12'd0, 18);
    run_setting(12'hfff, 12'hfff, 18);
    run_setting(12'd0, 12'd0, 6);      // zero window length
    run_setting(12'd0, 12'd1, 14);
    run_setting(12'hfff, 12'd0, 14);
    run_setting(12'd1, 12'hfff, 14);
    for (int k = 0; k < 4; k++)
      run_setting(RegBits'($urandom_range(1, 400)), RegBits'($urandom_range(0, 200)), 18);

    $display("%0d regions under %0d register settings, %0d chunks checked",
             regions_taken, settings_run, chunks_checked);
    $display("%0d regions over the window limit or with a zero window", too_long_cnt);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d chunks still expected", expected_chunks.size());
    $display("simulation failed");
    $finish;
  end

endmodule
